// ----- rtl/core/plle_pkg.sv -----
// Shared types, constants and command/status structs for the linked-list engine.
package plle_pkg;

  localparam int CAPACITY = 16;
  localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 5;
  // Working position width: holds the input position and count + 1.
  localparam int PQ_W     = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [PQ_W-1:0]   pq_t;
  typedef slot_t link_arr_t [CAPACITY];

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR    = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_APPEND   = 3'd3,
    OP_DEL_HEAD = 3'd4,
    OP_DEL_TAIL = 3'd5,
    OP_DEL_POS  = 3'd6,
    OP_TRAVERSE = 3'd7
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    POS_IN     = 2'd0,
    POS_ONE    = 2'd1,
    POS_APPEND = 2'd2,
    POS_LAST   = 2'd3
  } pos_sel_e;

  // One cycle's worth of datapath micro-operations.
  typedef struct packed {
    logic     load;
    pos_sel_e pos_sel;
    logic     init;
    logic     take;
    logic     ins_head;
    logic     cur_head;
    logic     cur_tail;
    logic     walk_step;
    logic     link1;
    logic     link2;
    logic     del_head;
    logic     grab;
    logic     unlink;
    logic     free_slot;
    logic     emit_status;
    logic     emit_value;
    status_e  status;
    logic     last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_one;
    logic ins_pos_ok;
    logic del_pos_ok;
    logic walk_done;
    logic trav_last;
    logic out_free;
  } sts_t;

  // Every slot links to the next one, the last wraps to slot zero.
  function automatic link_arr_t free_chain();
    link_arr_t chain;
    for (int i = 0; i < CAPACITY; i++) begin
      chain[i] = (i == CAPACITY - 1) ? slot_t'(0) : slot_t'(i + 1);
    end
    return chain;
  endfunction

endpackage

// ----- rtl/core/plle_dp.sv -----
// Datapath: node store, list pointers, walk pointer and the result register.
module plle_dp import plle_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  input  logic [POS_W-1:0]           position_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  input  logic                       out_ready_i,
  output sts_t                       sts_o,
  output logic                       out_valid_o,
  output logic signed [VALUE_W-1:0]  item_value_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [ENTRY_W-1:0]         entry_count_o,
  output logic                       last_of_run_o
);

  link_arr_t                  links_q;
  logic signed [VALUE_W-1:0]  values_q [CAPACITY];

  slot_t head_q, tail_q, free_q, cur_q, slot_q;
  cnt_t  count_q;
  pq_t   k_q, pos_q, pos_d;
  logic signed [VALUE_W-1:0] value_q;

  slot_t rd_addr, rd_link, wr_addr, wr_data;
  logic  wr_en;
  logic  out_valid_q;
  pq_t   count_ext, count_inc;

  assign count_ext = pq_t'(count_q);
  assign count_inc = count_ext + pq_t'(1);

  // Single read port on the link store.
  always_comb begin
    priority if (cmd_i.take) begin
      rd_addr = free_q;
    end else if (cmd_i.del_head) begin
      rd_addr = head_q;
    end else if (cmd_i.unlink) begin
      rd_addr = slot_q;
    end else begin
      rd_addr = cur_q;
    end
  end
  assign rd_link = links_q[rd_addr];

  // Single write port on the link store.
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = slot_q;
    wr_data = rd_link;
    priority if (cmd_i.ins_head) begin
      wr_data = head_q;
    end else if (cmd_i.link1) begin
      wr_data = rd_link;
    end else if (cmd_i.link2) begin
      wr_addr = cur_q;
      wr_data = slot_q;
    end else if (cmd_i.del_head) begin
      wr_addr = head_q;
      wr_data = free_q;
    end else if (cmd_i.unlink) begin
      wr_addr = cur_q;
      wr_data = rd_link;
    end else if (cmd_i.free_slot) begin
      wr_data = free_q;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      links_q <= free_chain();
    end else if (cmd_i.init) begin
      links_q <= free_chain();
    end else if (wr_en) begin
      links_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      values_q[free_q] <= value_q;
    end
  end

  always_comb begin
    unique case (cmd_i.pos_sel)
      POS_IN:     pos_d = pq_t'(position_i);
      POS_ONE:    pos_d = pq_t'(1);
      POS_APPEND: pos_d = count_inc;
      POS_LAST:   pos_d = count_ext;
      default:    pos_d = pq_t'(position_i);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q   <= pos_d;
      value_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      free_q  <= '0;
      count_q <= '0;
      cur_q   <= '0;
      slot_q  <= '0;
      k_q     <= '0;
    end else if (cmd_i.init) begin
      head_q  <= '0;
      tail_q  <= '0;
      free_q  <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.take) begin
        slot_q <= free_q;
        free_q <= rd_link;
      end
      if (cmd_i.grab) begin
        slot_q <= rd_link;
      end
      if (cmd_i.cur_head) begin
        cur_q <= head_q;
        k_q   <= '0;
      end
      if (cmd_i.cur_tail) begin
        cur_q <= tail_q;
      end
      if (cmd_i.walk_step) begin
        cur_q <= rd_link;
        k_q   <= k_q + pq_t'(1);
      end
      if (cmd_i.ins_head) begin
        head_q  <= slot_q;
        count_q <= count_q + cnt_t'(1);
        if (count_q == '0) begin
          tail_q <= slot_q;
        end
      end
      if (cmd_i.link2) begin
        count_q <= count_q + cnt_t'(1);
        if (pos_q == count_inc) begin
          tail_q <= slot_q;
        end
      end
      if (cmd_i.unlink && (pos_q == count_ext)) begin
        tail_q <= cur_q;
      end
      if (cmd_i.del_head) begin
        head_q  <= rd_link;
        free_q  <= head_q;
        count_q <= count_q - cnt_t'(1);
      end
      if (cmd_i.free_slot) begin
        free_q  <= slot_q;
        count_q <= count_q - cnt_t'(1);
      end
      // The last entry leaves: both ends go back to slot zero.
      if ((cmd_i.del_head || cmd_i.free_slot) && (count_q == cnt_t'(1))) begin
        head_q <= '0;
        tail_q <= '0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_status || cmd_i.emit_value) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_value) begin
      item_value_o  <= values_q[cur_q];
      status_o      <= ST_OK;
      entry_count_o <= ENTRY_W'(count_q);
      last_of_run_o <= cmd_i.last;
    end else if (cmd_i.emit_status) begin
      item_value_o  <= '0;
      status_o      <= cmd_i.status;
      entry_count_o <= ENTRY_W'(count_q);
      last_of_run_o <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.full       = (count_q >= cnt_t'(CAPACITY));
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.pos_one    = (pos_q == pq_t'(1));
  assign sts_o.ins_pos_ok = (pos_q != '0) && (pos_q <= count_inc);
  assign sts_o.del_pos_ok = (pos_q != '0) && (pos_q <= count_ext);
  assign sts_o.walk_done  = ((k_q + pq_t'(2)) == pos_q);
  assign sts_o.trav_last  = ((k_q + pq_t'(1)) == count_ext);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ----- rtl/core/plle_ctrl.sv -----
// Controller: sequences each operation as datapath commands.
module plle_ctrl import plle_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] op_i,
  input  sts_t            sts_i,
  output logic            in_ready_o,
  output cmd_t            cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_TAKE    = 4'd2;
  localparam logic [3:0] S_INSHEAD = 4'd3;
  localparam logic [3:0] S_WALK    = 4'd4;
  localparam logic [3:0] S_LINK1   = 4'd5;
  localparam logic [3:0] S_LINK2   = 4'd6;
  localparam logic [3:0] S_DELHEAD = 4'd7;
  localparam logic [3:0] S_GRAB    = 4'd8;
  localparam logic [3:0] S_UNLINK  = 4'd9;
  localparam logic [3:0] S_FREE    = 4'd10;
  localparam logic [3:0] S_TRAV    = 4'd11;
  localparam logic [3:0] S_RESULT  = 4'd12;

  logic [3:0] state_q, state_d;
  op_e        op_q, op_d;
  status_e    st_q, st_d;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    st_d       = st_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = op_e'(op_i);
          unique case (op_e'(op_i))
            OP_INS_HEAD, OP_DEL_HEAD: cmd_o.pos_sel = POS_ONE;
            OP_APPEND:                cmd_o.pos_sel = POS_APPEND;
            OP_DEL_TAIL:              cmd_o.pos_sel = POS_LAST;
            default:                  cmd_o.pos_sel = POS_IN;
          endcase
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        st_d    = ST_OK;
        state_d = S_RESULT;
        unique case (op_q)
          OP_CLEAR: begin
            cmd_o.init = 1'b1;
          end
          OP_INS_HEAD, OP_INS_POS, OP_APPEND: begin
            if (sts_i.full) begin
              st_d = ST_FULL;
            end else if (!sts_i.ins_pos_ok) begin
              st_d = ST_RANGE;
            end else begin
              state_d = S_TAKE;
            end
          end
          OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
            if (sts_i.empty) begin
              st_d = ST_EMPTY;
            end else if (!sts_i.del_pos_ok) begin
              st_d = ST_RANGE;
            end else if (sts_i.pos_one) begin
              state_d = S_DELHEAD;
            end else begin
              cmd_o.cur_head = 1'b1;
              state_d        = S_WALK;
            end
          end
          OP_TRAVERSE: begin
            if (sts_i.empty) begin
              st_d = ST_EMPTY;
            end else begin
              cmd_o.cur_head = 1'b1;
              state_d        = S_TRAV;
            end
          end
          default: begin
            st_d = ST_OK;
          end
        endcase
      end
      S_TAKE: begin
        cmd_o.take = 1'b1;
        if (sts_i.pos_one) begin
          state_d = S_INSHEAD;
        end else if (op_q == OP_APPEND) begin
          // The tail is the predecessor of an appended entry.
          cmd_o.cur_tail = 1'b1;
          state_d        = S_LINK1;
        end else begin
          cmd_o.cur_head = 1'b1;
          state_d        = S_WALK;
        end
      end
      S_INSHEAD: begin
        cmd_o.ins_head = 1'b1;
        state_d        = S_RESULT;
      end
      S_WALK: begin
        if (sts_i.walk_done) begin
          state_d = (op_q == OP_INS_POS) ? S_LINK1 : S_GRAB;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_LINK1: begin
        cmd_o.link1 = 1'b1;
        state_d     = S_LINK2;
      end
      S_LINK2: begin
        cmd_o.link2 = 1'b1;
        state_d     = S_RESULT;
      end
      S_DELHEAD: begin
        cmd_o.del_head = 1'b1;
        state_d        = S_RESULT;
      end
      S_GRAB: begin
        cmd_o.grab = 1'b1;
        state_d    = S_UNLINK;
      end
      S_UNLINK: begin
        cmd_o.unlink = 1'b1;
        state_d      = S_FREE;
      end
      S_FREE: begin
        cmd_o.free_slot = 1'b1;
        state_d         = S_RESULT;
      end
      S_TRAV: begin
        if (sts_i.out_free) begin
          cmd_o.emit_value = 1'b1;
          cmd_o.last       = sts_i.trav_last;
          cmd_o.walk_step  = 1'b1;
          if (sts_i.trav_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          cmd_o.status      = st_q;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_CLEAR;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      st_q    <= st_d;
    end
  end

endmodule

// ----- rtl/core/positional_linked_list_engine.sv -----
// Top level of the positional linked-list engine.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------
//   input   | in        | in_valid_i / in_ready_o | op_i, position_i, value_i
//   result  | out       | out_valid_o/out_ready_i | item_value_o, status_o,
//           |           |                        | entry_count_o, last_of_run_o
//
// One operation is in flight at a time: idle accepts it, decode checks it. An
// insert takes a free slot; insert at head links it as head, append after the
// tail, and positional insert and delete walk one link per cycle through the
// single read port of the link store. Delete head unlinks the head, a tail
// delete uses the count as its position, traverse emits each entry in turn, and
// position one runs as a head operation. Status results use the result state.
// Reset restores the free list at once; no clearing pass follows. A stalled
// result holds its beat; the sequencer waits and takes no new input.
module positional_linked_list_engine import plle_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [OP_W-1:0]            op_i,
  input  logic [POS_W-1:0]           position_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [VALUE_W-1:0]  item_value_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [ENTRY_W-1:0]         entry_count_o,
  output logic                       last_of_run_o
);

  cmd_t cmd;
  sts_t sts;

  plle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  plle_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_ready_i   (out_ready_i),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .item_value_o  (item_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ----- rtl/core/plle_checker.sv -----
// Port-level checks for the linked-list engine and their bind to the top level.
module plle_checker import plle_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [VALUE_W-1:0]  item_value_o,
  input logic [STATUS_W-1:0]        status_o,
  input logic [ENTRY_W-1:0]         entry_count_o,
  input logic                       last_of_run_o
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(item_value_o) &&
      $stable(status_o) && $stable(entry_count_o) && $stable(last_of_run_o))
    else $error("result beat changed while stalled");

  // The engine is busy right after it takes an input beat.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again in the cycle after an accept");

  // Only a traverse gives non-final beats, and those carry a non-empty list.
  a_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> status_o == ST_OK && entry_count_o != '0)
    else $error("non-final result beat outside a traverse");

  // Error results never carry a list value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> item_value_o == '0 && last_of_run_o)
    else $error("error result carries a value or continues the run");

endmodule

bind positional_linked_list_engine plle_checker u_plle_checker (.*);
